// ----- rtl/btss_pkg.sv -----
// Shared types, sizes and helpers for the texel store and sampler.
// Used by every module of the block but btss_ram; depends on nothing.
package btss_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int MEM_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int DIM_W       = 9;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int COORD_W     = 24;
  localparam int TEXEL_W     = 24;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_W      = 32;
  localparam int MOD_STEPS   = 4;
  localparam int MOD_BITS    = 4;
  localparam int MAG_W       = MOD_STEPS * MOD_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(MAX_HEIGHT);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic {
    MODE_CLAMP = 1'b0,
    MODE_WRAP  = 1'b1
  } mode_e;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } dims_t;

  typedef struct packed {
    op_e                op;
    mode_e              mode;
    logic [COORD_W-1:0] a;
    logic [COORD_W-1:0] b;
  } qentry_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] d;
    if (r == '0) begin
      d = DIM_W'(1);
    end else if (r > maxv) begin
      d = maxv;
    end else begin
      d = r;
    end
    return d;
  endfunction

endpackage

// ----- rtl/btss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module btss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/btss_queue.sv -----
// Short command queue between the front and back parts.
// Depends on btss_pkg for the entry type and depth.
module btss_queue
  import btss_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  qentry_t push_entry,
  input  logic    pop,
  output qentry_t head,
  output logic    empty,
  output logic    full
);

  qentry_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty queue");

endmodule

// ----- rtl/btss_front.sv -----
// Front part: takes items, assembles texels from the byte stream with row flip
// and padding skip, and pushes memory writes and sample commands. Uses btss_pkg.
module btss_front
  import btss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               restart,
  input  dims_t              dims,
  input  logic               accept,
  input  logic               operation,
  input  logic [7:0]         pixel_byte,
  input  logic [COORD_W-1:0] coord_u,
  input  logic [COORD_W-1:0] coord_v,
  input  logic               address_mode,
  output logic               push,
  output qentry_t            push_entry
);

  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [1:0]       byte_phase;
  logic [1:0]       pad_remaining;
  logic [15:0]      partial_texel;

  op_e              op;
  logic [COL_W-1:0] col_g;
  logic [ROW_W-1:0] row_g;
  logic [ROW_W-1:0] flip_row;
  logic [ADDR_W:0]  row_base;
  logic [ADDR_W-1:0] waddr;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] row_inc;
  logic             texel_done;

  assign op       = op_e'(operation);
  assign col_g    = (DIM_W'(column_count) < dims.w) ? column_count : '0;
  assign row_g    = (DIM_W'(row_count) < dims.h) ? row_count : '0;
  assign flip_row = ROW_W'(dims.h - DIM_W'(1) - DIM_W'(row_g));
  assign row_base = (ADDR_W + 1)'(flip_row) * (ADDR_W + 1)'(dims.w);
  assign waddr    = ADDR_W'(row_base + (ADDR_W + 1)'(col_g));
  assign col_inc  = DIM_W'(col_g) + DIM_W'(1);
  assign row_inc  = DIM_W'(row_g) + DIM_W'(1);

  assign texel_done = accept && (op == OP_LOAD) && (pad_remaining == '0)
                      && (byte_phase == PH_RED);
  assign push       = (accept && (op == OP_SAMPLE)) || texel_done;

  always_comb begin
    push_entry.op = op;
    if (op == OP_SAMPLE) begin
      push_entry.mode = mode_e'(address_mode);
      push_entry.a    = coord_u;
      push_entry.b    = coord_v;
    end else begin
      push_entry.mode = MODE_CLAMP;
      push_entry.a    = {pixel_byte, partial_texel};
      push_entry.b    = COORD_W'(waddr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_count  <= '0;
      row_count     <= '0;
      byte_phase    <= PH_BLUE;
      pad_remaining <= '0;
      partial_texel <= '0;
    end else if (accept && (op == OP_LOAD)) begin
      if (pad_remaining != '0) begin
        pad_remaining <= pad_remaining - 2'd1;
      end else begin
        case (byte_phase)
          PH_BLUE: begin
            partial_texel <= {8'd0, pixel_byte};
            byte_phase    <= PH_GREEN;
          end
          PH_GREEN: begin
            partial_texel[15:8] <= pixel_byte;
            byte_phase          <= PH_RED;
          end
          default: begin
            byte_phase <= PH_BLUE;
            if (col_inc >= dims.w) begin
              column_count  <= '0;
              pad_remaining <= dims.w[1:0];
              row_count     <= (row_inc >= dims.h) ? '0 : ROW_W'(row_inc);
            end else begin
              column_count <= COL_W'(col_inc);
              row_count    <= row_g;
            end
          end
        endcase
      end
    end
  end

endmodule

// ----- rtl/btss_back.sv -----
// Back part: drains the queue, writes texels, maps sample coordinates
// (scale, truncate, clamp or wrap) and reads the texel memory. Uses btss_pkg, btss_ram.
module btss_back
  import btss_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  dims_t         dims,
  input  qentry_t       head,
  input  logic          empty,
  output logic          pop,
  output logic          done,
  output logic [7:0]    texel_red,
  output logic [7:0]    texel_green,
  output logic [7:0]    texel_blue
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCALE = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_FIX   = 7'b0001000,
    S_ADDR  = 7'b0010000,
    S_READ  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [PROD_W-1:0] prod_u;
  logic signed [PROD_W-1:0] prod_v;
  mode_e                    mode;
  logic [MAG_W-1:0]         mag_u;
  logic [MAG_W-1:0]         mag_v;
  logic [MAG_W-1:0]         sh_u;
  logic [MAG_W-1:0]         sh_v;
  logic                     neg_u;
  logic                     neg_v;
  logic [DIM_W-1:0]         rem_u;
  logic [DIM_W-1:0]         rem_v;
  logic [1:0]               step;
  logic [COL_W-1:0]         x;
  logic [ROW_W-1:0]         y;
  logic [ADDR_W-1:0]        addr;

  logic signed [PROD_W-1:0] u_ext;
  logic signed [PROD_W-1:0] v_ext;
  logic signed [PROD_W-1:0] wm1_ext;
  logic signed [PROD_W-1:0] hm1_ext;
  logic [PROD_W-1:0]        abs_u;
  logic [PROD_W-1:0]        abs_v;
  logic                     we;
  logic                     re;
  logic [TEXEL_W-1:0]       rdata;

  function automatic logic [DIM_W-1:0] mod_step(input logic [DIM_W-1:0] r,
                                                input logic [MOD_BITS-1:0] bits,
                                                input logic [DIM_W-1:0] d);
    logic [DIM_W:0]   t;
    logic [DIM_W-1:0] acc;
    acc = r;
    for (int i = MOD_BITS - 1; i >= 0; i--) begin
      t = {acc, bits[i]};
      if (t >= (DIM_W + 1)'(d)) begin
        t = t - (DIM_W + 1)'(d);
      end
      acc = t[DIM_W-1:0];
    end
    return acc;
  endfunction

  function automatic logic [DIM_W-1:0] map_index(input mode_e m,
                                                 input logic neg,
                                                 input logic [MAG_W-1:0] mag,
                                                 input logic [DIM_W-1:0] rem,
                                                 input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] idx;
    if (m == MODE_WRAP) begin
      idx = (neg && rem != '0) ? (d - rem) : rem;
    end else if (neg) begin
      idx = '0;
    end else if (mag > MAG_W'(d - DIM_W'(1))) begin
      idx = d - DIM_W'(1);
    end else begin
      idx = DIM_W'(mag);
    end
    return idx;
  endfunction

  assign u_ext   = PROD_W'($signed(head.a));
  assign v_ext   = PROD_W'($signed(head.b));
  assign wm1_ext = $signed(PROD_W'(dims.w - DIM_W'(1)));
  assign hm1_ext = $signed(PROD_W'(dims.h - DIM_W'(1)));
  assign abs_u   = prod_u[PROD_W-1] ? PROD_W'(-prod_u) : PROD_W'(prod_u);
  assign abs_v   = prod_v[PROD_W-1] ? PROD_W'(-prod_v) : PROD_W'(prod_v);

  assign pop  = (state == S_IDLE) && !empty;
  assign we   = pop && (head.op == OP_LOAD);
  assign re   = (state == S_READ);
  assign done = (state == S_OUT);

  assign texel_red   = rdata[23:16];
  assign texel_green = rdata[15:8];
  assign texel_blue  = rdata[7:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pop && head.op == OP_SAMPLE) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: state_next = S_MOD;
      S_MOD: begin
        if (step == 2'(MOD_STEPS - 1)) begin
          state_next = S_FIX;
        end
      end
      S_FIX:  state_next = S_ADDR;
      S_ADDR: state_next = S_READ;
      S_READ: state_next = S_OUT;
      S_OUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        prod_u <= u_ext * wm1_ext;
        prod_v <= v_ext * hm1_ext;
        mode   <= head.mode;
      end
      S_SCALE: begin
        mag_u <= abs_u[FRAC_BITS +: MAG_W];
        mag_v <= abs_v[FRAC_BITS +: MAG_W];
        sh_u  <= abs_u[FRAC_BITS +: MAG_W];
        sh_v  <= abs_v[FRAC_BITS +: MAG_W];
        neg_u <= prod_u[PROD_W-1];
        neg_v <= prod_v[PROD_W-1];
        rem_u <= '0;
        rem_v <= '0;
        step  <= '0;
      end
      S_MOD: begin
        rem_u <= mod_step(rem_u, sh_u[MAG_W-1 -: MOD_BITS], dims.w);
        rem_v <= mod_step(rem_v, sh_v[MAG_W-1 -: MOD_BITS], dims.h);
        sh_u  <= sh_u << MOD_BITS;
        sh_v  <= sh_v << MOD_BITS;
        step  <= step + 2'd1;
      end
      S_FIX: begin
        x <= COL_W'(map_index(mode, neg_u, mag_u, rem_u, dims.w));
        y <= ROW_W'(map_index(mode, neg_v, mag_v, rem_v, dims.h));
      end
      S_ADDR: begin
        addr <= ADDR_W'((ADDR_W + 1)'(y) * (ADDR_W + 1)'(dims.w) + (ADDR_W + 1)'(x));
      end
      default: begin
      end
    endcase
  end

  btss_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (MEM_DEPTH)
  ) u_texel_ram (
    .clk   (clk),
    .we    (we),
    .waddr (head.b[ADDR_W-1:0]),
    .wdata (head.a),
    .re    (re),
    .raddr (addr),
    .rdata (rdata)
  );

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");
  a_read_then_done: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> done)
    else $error("memory read not followed by result");

endmodule

// ----- rtl/bmp_texel_store_sampler_top.sv -----
// Top level of the texel store and nearest sampler: register port, front,
// queue and back. Depends on btss_pkg, btss_front, btss_queue, btss_back.
//
// Usage:
//   Items enter on start while busy is low. A load item (operation 0) carries
//   one byte of a 24-bit bottom-up bitmap stream (blue, green, red, rows padded
//   to 4 bytes); every third data byte writes one texel, rows stored flipped.
//   A sample item (operation 1) carries Q8.16 coord_u/coord_v and address_mode
//   (clamp or wrap) and gives one texel on texel_red/green/blue with done high
//   for exactly one cycle; there is no way to hold a result off.
//   Loads are taken one per cycle while busy is low. In the back part a sample
//   passes in order through a scaling multiply, truncation, a 4-bit-per-cycle
//   remainder unit for wrap, index fix, address multiply, memory read and output;
//   the back part takes no new entry until that result is out. The four-entry
//   queue lets the front keep taking items meanwhile, and busy rises only when
//   it is full.
//   image_width (offset 0) and image_height (offset 4) are written over the
//   APB port; a write restarts the byte stream at the first texel.
//   Reset sets both sizes to 256 and clears stream position and queue; the
//   texel memory is not cleared and reads of unloaded texels are undefined.
module bmp_texel_store_sampler_top
  import btss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic [7:0]         pixel_byte,
  input  logic [COORD_W-1:0] coord_u,
  input  logic [COORD_W-1:0] coord_v,
  input  logic               address_mode,
  output logic               done,
  output logic [7:0]         texel_red,
  output logic [7:0]         texel_green,
  output logic [7:0]         texel_blue,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             cfg_write;
  dims_t            dims;
  logic             accept;
  logic             push;
  qentry_t          push_entry;
  qentry_t          head;
  logic             pop;
  logic             empty;
  logic             full;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign accept    = start && !busy;
  assign busy      = full;

  assign dims.w = eff_dim(image_width, DIM_W'(MAX_WIDTH));
  assign dims.h = eff_dim(image_height, DIM_W'(MAX_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: image_height <= pwdata[DIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = PDATA_W'(image_width);
      REG_HEIGHT: prdata = PDATA_W'(image_height);
    endcase
  end

  btss_front u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (cfg_write),
    .dims         (dims),
    .accept       (accept),
    .operation    (operation),
    .pixel_byte   (pixel_byte),
    .coord_u      (coord_u),
    .coord_v      (coord_v),
    .address_mode (address_mode),
    .push         (push),
    .push_entry   (push_entry)
  );

  btss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  btss_back u_back (
    .clk         (clk),
    .rst         (rst),
    .dims        (dims),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .done        (done),
    .texel_red   (texel_red),
    .texel_green (texel_green),
    .texel_blue  (texel_blue)
  );

endmodule
